// File: hw/rtl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants for the vertex normal averager
// Operation codes and the control record passed to the divider.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
    localparam logic [1:0] OP_LOAD_FACE   = 2'd1;
    localparam logic [1:0] OP_QUERY       = 2'd2;

    localparam int CORNERS  = 3;
    localparam int SUM_BITS = 24;
    localparam int CNT_BITS = 7;

    // request to the rounding divider
    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] sum;
        logic [CNT_BITS-1:0]        count;
    } div_req_t;

    // answer of the rounding divider
    typedef struct packed {
        logic              done;
        logic signed [15:0] quot;
    } div_rsp_t;

endpackage

// File: hw/rtl/vna_divider.sv
// ----------------------------------------------------------------------------
// vna_divider: rounded signed division
// Restoring division one bit per cycle, ties rounded away from zero.
// ----------------------------------------------------------------------------
module vna_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  vna_pkg::div_req_t req,
    output vna_pkg::div_rsp_t rsp
);
    localparam int SB = vna_pkg::SUM_BITS;
    localparam int CB = vna_pkg::CNT_BITS;

    logic          busy_reg;
    logic [4:0]    step_reg;
    logic          neg_reg;
    logic [SB:0]   num_reg;
    logic [SB:0]   rem_reg;
    logic [SB:0]   quo_reg;
    logic [CB-1:0] den_reg;
    logic          done_reg;
    logic [SB:0]   rem_sh;
    logic [SB:0]   mag;
    logic [SB:0]   qn;

    // magnitude of the signed sum; half the divisor is added when the request is loaded
    assign mag = req.sum[SB-1] ? (SB+1)'(-{req.sum[SB-1], req.sum})
                               : (SB+1)'({req.sum[SB-1], req.sum});
    assign rem_sh = {rem_reg[SB-1:0], num_reg[SB]};
    assign qn = neg_reg ? -quo_reg : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 5'd0;
                neg_reg  <= req.sum[SB-1];
                num_reg  <= mag + (SB+1)'(req.count >> 1);
                den_reg  <= req.count;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[SB-1:0], 1'b0};
                if (rem_sh >= (SB+1)'(den_reg)) begin
                    rem_reg <= rem_sh - (SB+1)'(den_reg);
                    quo_reg <= {quo_reg[SB-1:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[SB-1:0], 1'b0};
                end
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(SB)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = qn[15:0];
endmodule

// File: hw/rtl/vertex_normal_averager.sv
// ----------------------------------------------------------------------------
// vertex_normal_averager: smooth vertex normal averaging
// Vertex and face stores with a face walk per query and a rounded average.
// ----------------------------------------------------------------------------
// loads are written as they are accepted; a query reads each walked face, then its three
// corner vertices, scans the unique list for each matching face to drop duplicates,
// then sums and divides each component for the rounded average (zero when no face matches)
// one item in flight at a time; the result register frees the input side
// reset clears control and face_count; stores are undefined until written
module vertex_normal_averager #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_FACES    = 1024,
    parameter int MAX_UNIQUE   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [10:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, corner_a, b, c
    input  logic [135:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // avg_x, avg_y, avg_z, unique_count, no_face, list_overflow (pad 1)
    output logic [55:0]  m_tdata
);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int FW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int UW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int SB = vna_pkg::SUM_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_TGT = 4'd1, ST_FACE = 4'd2,
        ST_CA = 4'd3, ST_CB = 4'd4, ST_CC = 4'd5, ST_NRM = 4'd6,
        ST_DUP = 4'd7, ST_SUM = 4'd8, ST_DIV = 4'd9, ST_OUT = 4'd10,
        ST_FDATA = 4'd11;

    // unpack the input transfer
    logic [9:0]  in_slot;
    logic [47:0] in_pos, in_nrm;
    logic [29:0] in_corners;
    assign in_slot    = s_tdata[9:0];
    assign in_pos     = s_tdata[57:10];
    assign in_nrm     = s_tdata[105:58];
    assign in_corners = s_tdata[135:106];

    // stores
    logic [47:0] pos_mem [MAX_VERTICES];
    logic [47:0] nrm_mem [MAX_VERTICES];
    logic [29:0] face_mem [MAX_FACES];
    logic [47:0] uniq_reg [MAX_UNIQUE];

    logic [3:0]  state_reg;
    logic [10:0] face_count_reg;
    logic [16:0] fidx_reg;
    logic [16:0] walk_reg;
    logic [47:0] target_reg, nrm_cur_reg;
    logic [29:0] face_reg;
    logic        hit_reg, any_reg, ovf_reg, dup_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  scan_reg;
    logic [1:0]  comp_reg;
    logic signed [SB-1:0] sum_reg;
    logic [47:0] avg_reg;
    logic        m_valid_reg;
    logic [55:0] m_data_reg;

    logic [9:0]  vaddr;
    logic        vaddr_ok_reg;
    logic [47:0] pos_q_reg, nrm_q_reg, pos_rd, nrm_rd;
    logic [29:0] face_q_reg;
    logic        s_acc;
    logic        out_load;
    logic [47:0] uentry;
    vna_pkg::div_req_t dreq;
    vna_pkg::div_rsp_t drsp;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // vertex read address per state
    always_comb begin
        case (state_reg)
            ST_IDLE: vaddr = in_slot;
            ST_FDATA: vaddr = face_q_reg[9:0];
            ST_CA:   vaddr = face_reg[19:10];
            ST_CB:   vaddr = face_reg[29:20];
            ST_CC:   vaddr = face_reg[9:0];
            default: vaddr = face_reg[9:0];
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == vna_pkg::OP_LOAD_VERTEX
                && 32'(in_slot) < MAX_VERTICES) begin
            pos_mem[VW'(in_slot)] <= in_pos;
            nrm_mem[VW'(in_slot)] <= in_nrm;
        end
        if (s_acc && s_tuser == vna_pkg::OP_LOAD_FACE && 32'(in_slot) < MAX_FACES)
            face_mem[FW'(in_slot)] <= in_corners;
        pos_q_reg    <= pos_mem[VW'(vaddr)];
        nrm_q_reg    <= nrm_mem[VW'(vaddr)];
        vaddr_ok_reg <= 32'(vaddr) < MAX_VERTICES;
        face_q_reg   <= face_mem[FW'(fidx_reg)];
    end
    assign pos_rd = vaddr_ok_reg ? pos_q_reg : '0;
    assign nrm_rd = vaddr_ok_reg ? nrm_q_reg : '0;

    assign uentry = uniq_reg[UW'(scan_reg)];

    vna_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));
    assign dreq.start = (state_reg == ST_SUM) && (scan_reg == cnt_reg);
    assign dreq.sum   = sum_reg;
    assign dreq.count = cnt_reg;

    // query sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            face_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) face_count_reg <= cfg_wdata;
            // result register: load a finished result, clear on the output transfer
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_acc && s_tuser == vna_pkg::OP_QUERY) begin
                    state_reg <= ST_TGT;
                    fidx_reg  <= '0;
                    walk_reg  <= (32'(face_count_reg) > MAX_FACES)
                                 ? 17'(MAX_FACES) : 17'(face_count_reg);
                    cnt_reg <= '0;
                    any_reg <= 1'b0;
                    ovf_reg <= 1'b0;
                end
                ST_TGT: begin
                    target_reg <= pos_rd;
                    state_reg  <= ST_FACE;
                end
                ST_FACE: begin
                    if (fidx_reg == walk_reg) begin
                        state_reg <= ST_SUM;
                        scan_reg  <= '0;
                        comp_reg  <= '0;
                        sum_reg   <= '0;
                    end else state_reg <= ST_FDATA;
                end
                ST_FDATA: begin
                    face_reg  <= face_q_reg;
                    state_reg <= ST_CA;
                end
                ST_CA: begin
                    hit_reg     <= pos_rd == target_reg;
                    nrm_cur_reg <= nrm_rd;
                    state_reg   <= ST_CB;
                end
                ST_CB: begin
                    hit_reg   <= hit_reg || pos_rd == target_reg;
                    state_reg <= ST_CC;
                end
                ST_CC: begin
                    if (hit_reg || pos_rd == target_reg) begin
                        any_reg   <= 1'b1;
                        scan_reg  <= '0;
                        dup_reg   <= 1'b0;
                        state_reg <= ST_DUP;
                    end else begin
                        fidx_reg  <= fidx_reg + 17'd1;
                        state_reg <= ST_FACE;
                    end
                end
                ST_DUP: begin
                    if (scan_reg == cnt_reg) begin
                        if (!dup_reg) begin
                            if (32'(cnt_reg) < MAX_UNIQUE) begin
                                uniq_reg[UW'(cnt_reg)] <= nrm_cur_reg;
                                cnt_reg <= cnt_reg + 7'd1;
                            end else ovf_reg <= 1'b1;
                        end
                        fidx_reg  <= fidx_reg + 17'd1;
                        state_reg <= ST_FACE;
                    end else begin
                        if (uentry == nrm_cur_reg) dup_reg <= 1'b1;
                        scan_reg <= scan_reg + 7'd1;
                    end
                end
                ST_SUM: begin
                    if (scan_reg == cnt_reg) begin
                        if (cnt_reg == '0) begin
                            avg_reg   <= '0;
                            state_reg <= ST_OUT;
                        end else state_reg <= ST_DIV;
                    end else begin
                        sum_reg <= sum_reg + SB'($signed(uentry[16*comp_reg +: 16]));
                        scan_reg <= scan_reg + 7'd1;
                    end
                end
                ST_DIV: if (drsp.done) begin
                    avg_reg[16*comp_reg +: 16] <= drsp.quot;
                    if (comp_reg == 2'd2) state_reg <= ST_OUT;
                    else begin
                        comp_reg  <= comp_reg + 2'd1;
                        scan_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_OUT: if (out_load) begin
                    m_data_reg <= {1'b0, ovf_reg, !any_reg, cnt_reg[4:0], avg_reg};
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= MAX_UNIQUE || state_reg == ST_IDLE) else $error("count");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready) else $error("busy accept");
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT) else $error("out");
endmodule
